>>> rtl/byte_stream_reassembler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream reassembler.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_CORE_ASSERT_SVH
`define BYTE_STREAM_REASSEMBLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsr assertion failed");

`endif

>>> rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants and transfer types of the byte stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned IndexW     = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PendOutW   = 7;

  // One classified input item as it waits between the front and the back.
  typedef struct packed {
    logic              has_byte;
    logic [ByteW-1:0]  byte_value;
    logic [IndexW-1:0] byte_index;
    logic              eof_flag;
    logic [IndexW-1:0] fin_index;
  } item_t;

  // One result as it waits for the consumer.
  typedef struct packed {
    logic                out_valid;
    logic [ByteW-1:0]    out_byte;
    logic                stream_done;
    logic [PendOutW-1:0] pending_count;
    logic                run_last;
  } result_t;

endpackage

>>> rtl/byte_stream_reassembler_core.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembler_core
// Rebuilds an in-order byte stream from bytes that arrive out of order, each
// tagged with its 32-bit stream index. Bytes inside the window of Capacity
// bytes from the next expected index are kept in a ring with a valid bit per
// slot; all others are dropped, and duplicates keep the first value. Every
// item produces one result per byte it releases in order, or one empty
// result if it releases none; run_last marks its final result. The back
// part's state machine sets the rate: it applies an item, then emits one
// result per cycle while the result queue has room, and takes no new item
// until the last result of the current one is out. Queues of QueueDepth
// entries on both sides let the producer and the consumer stall on their
// own. The ring's valid bits clear at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "byte_stream_reassembler_core_assert.svh"

module byte_stream_reassembler_core #(
  parameter int unsigned Capacity   = bsr_pkg::Capacity,
  parameter int unsigned QueueDepth = bsr_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         has_byte_i,
  input  logic [bsr_pkg::ByteW-1:0]    byte_value_i,
  input  logic [bsr_pkg::IndexW-1:0]   byte_index_i,
  input  logic                         eof_flag_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_valid_o,
  output logic [bsr_pkg::ByteW-1:0]    out_byte_o,
  output logic                         stream_done_o,
  output logic [bsr_pkg::PendOutW-1:0] pending_count_o,
  output logic                         run_last_o
);

  bsr_pkg::item_t                      item;
  logic                                item_valid;
  logic                                item_pop;
  bsr_pkg::result_t                    res;
  logic                                res_push;
  logic                                res_full;
  logic [$bits(bsr_pkg::result_t)-1:0] res_bits;
  bsr_pkg::result_t                    res_out;

  bsr_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .has_byte_i   (has_byte_i),
    .byte_value_i (byte_value_i),
    .byte_index_i (byte_index_i),
    .eof_flag_i   (eof_flag_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  bsr_back #(
    .Capacity (Capacity)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  bsr_fifo #(
    .Width ($bits(bsr_pkg::result_t)),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty)
  );

  assign res_out         = bsr_pkg::result_t'(res_bits);
  assign out_valid_o     = res_out.out_valid;
  assign out_byte_o      = res_out.out_byte;
  assign stream_done_o   = res_out.stream_done;
  assign pending_count_o = res_out.pending_count;
  assign run_last_o      = res_out.run_last;

  // An empty result always closes the run of its item.
  `BSR_ASSERT_SAME(a_empty_res_last, clk_i, rst_ni, res_push && !res.out_valid, res.run_last)

  // The end of the stream, once reported, stays reported.
  `BSR_ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, !empty && pop && stream_done_o, empty || stream_done_o)

  // The ring never holds more bytes than it has slots.
  `BSR_ASSERT_SAME(a_pending_cap, clk_i, rst_ni, !empty, pending_count_o <= bsr_pkg::PendOutW'(Capacity))

endmodule

>>> rtl/bsr_fifo.sv
// ----------------------------------------------------------------------------
// bsr_fifo
// Small register queue with full and empty flags, used between the parts.
// ----------------------------------------------------------------------------
module bsr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Accepts input items, works out the end index that an end mark would set,
// and queues the classified items for the back part.
// ----------------------------------------------------------------------------
module bsr_front #(
  parameter int unsigned QueueDepth = bsr_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       has_byte_i,
  input  logic [bsr_pkg::ByteW-1:0]  byte_value_i,
  input  logic [bsr_pkg::IndexW-1:0] byte_index_i,
  input  logic                       eof_flag_i,
  output bsr_pkg::item_t             item_o,
  output logic                       item_valid_o,
  input  logic                       item_pop_i
);

  bsr_pkg::item_t                 item_in;
  logic [$bits(bsr_pkg::item_t)-1:0] item_bits;
  logic                           item_empty;

  // The end index covers the byte itself when the item carries one.
  always_comb begin
    item_in.has_byte   = has_byte_i;
    item_in.byte_value = byte_value_i;
    item_in.byte_index = byte_index_i;
    item_in.eof_flag   = eof_flag_i;
    item_in.fin_index  = byte_index_i + bsr_pkg::IndexW'(has_byte_i);
  end

  bsr_fifo #(
    .Width ($bits(bsr_pkg::item_t)),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item_in),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (item_bits),
    .empty_o (item_empty)
  );

  assign item_o       = bsr_pkg::item_t'(item_bits);
  assign item_valid_o = !item_empty;

endmodule

>>> rtl/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back
// Applies queued items to the reorder ring and drains the contiguous run at
// the head into the result queue, one byte per cycle while it has room.
// ----------------------------------------------------------------------------
module bsr_back #(
  parameter int unsigned Capacity = bsr_pkg::Capacity
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsr_pkg::item_t   item_i,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  output bsr_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i
);

  localparam int unsigned SlotW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned PendW = $clog2(Capacity + 1);
  localparam logic [SlotW:0]  CapWide  = (SlotW + 1)'(Capacity);
  localparam logic [bsr_pkg::IndexW-1:0] CapIdx = bsr_pkg::IndexW'(Capacity);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Capacity - 1);

  typedef enum logic [1:0] {
    StFetch = 2'b01,
    StDrain = 2'b10
  } back_state_e;

  back_state_e                 state_q, state_d;
  logic [Capacity-1:0]         valid_q, valid_d;
  logic [bsr_pkg::IndexW-1:0]  head_q, head_d;
  logic [SlotW-1:0]            head_slot_q, head_slot_d;
  logic                        fin_known_q, fin_known_d;
  logic [bsr_pkg::IndexW-1:0]  fin_index_q, fin_index_d;
  logic [PendW-1:0]            pending_q, pending_d;
  logic                        ended_q, ended_d;

  logic [bsr_pkg::ByteW-1:0]   store_mem [Capacity];
  logic [bsr_pkg::ByteW-1:0]   rd_q;
  logic [SlotW-1:0]            rd_addr;

  logic [bsr_pkg::IndexW-1:0]  off;
  logic                        in_win;
  logic [SlotW:0]              slot_sum;
  logic [SlotW-1:0]            wslot;
  logic                        wr_en;
  logic [SlotW-1:0]            slot_nx;
  logic                        nx_vld;
  logic [bsr_pkg::IndexW-1:0]  head_inc;
  bsr_pkg::result_t            res_d;

  // Bytes behind the head wrap to a large offset and fall outside the window.
  assign off      = item_i.byte_index - head_q;
  assign in_win   = item_i.has_byte && (off < CapIdx);
  assign slot_sum = {1'b0, head_slot_q} + {1'b0, off[SlotW-1:0]};
  assign wslot    = (slot_sum >= CapWide) ? SlotW'(slot_sum - CapWide) : slot_sum[SlotW-1:0];
  assign wr_en    = (state_q == StFetch) && item_valid_i && in_win && !valid_q[wslot];
  assign slot_nx  = (head_slot_q == LastSlot) ? '0 : head_slot_q + SlotW'(1);
  // With a single slot the next slot is the one being drained right now.
  assign nx_vld   = valid_q[slot_nx] && (slot_nx != head_slot_q);
  assign head_inc = head_q + bsr_pkg::IndexW'(1);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    head_d      = head_q;
    head_slot_d = head_slot_q;
    fin_known_d = fin_known_q;
    fin_index_d = fin_index_q;
    pending_d   = pending_q;
    ended_d     = ended_q;
    item_pop_o  = 1'b0;
    res_push_o  = 1'b0;
    res_d       = '0;
    rd_addr     = head_slot_q;
    case (state_q)
      StFetch: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (wr_en) begin
            valid_d[wslot] = 1'b1;
            pending_d      = pending_q + PendW'(1);
          end
          if (item_i.eof_flag && !fin_known_q) begin
            fin_known_d = 1'b1;
            fin_index_d = item_i.fin_index;
          end
          if (fin_known_d && (head_q == fin_index_d)) begin
            ended_d = 1'b1;
          end
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (valid_q[head_slot_q]) begin
            valid_d[head_slot_q] = 1'b0;
            head_d      = head_inc;
            head_slot_d = slot_nx;
            pending_d   = pending_q - PendW'(1);
            if (fin_known_q && (head_inc == fin_index_q)) begin
              ended_d = 1'b1;
            end
            res_d.out_valid     = 1'b1;
            res_d.out_byte      = rd_q;
            res_d.stream_done   = ended_d;
            res_d.pending_count = bsr_pkg::PendOutW'(pending_d);
            res_d.run_last      = !nx_vld;
            rd_addr             = slot_nx;
            if (!nx_vld) begin
              state_d = StFetch;
            end
          end else begin
            // Nothing to drain: the item still gets one empty result.
            res_d.stream_done   = ended_q;
            res_d.pending_count = bsr_pkg::PendOutW'(pending_q);
            res_d.run_last      = 1'b1;
            state_d             = StFetch;
          end
        end
      end
      default: begin
        state_d = StFetch;
      end
    endcase
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFetch;
      valid_q     <= '0;
      head_q      <= '0;
      head_slot_q <= '0;
      fin_known_q <= 1'b0;
      fin_index_q <= '0;
      pending_q   <= '0;
      ended_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      head_q      <= head_d;
      head_slot_q <= head_slot_d;
      fin_known_q <= fin_known_d;
      fin_index_q <= fin_index_d;
      pending_q   <= pending_d;
      ended_q     <= ended_d;
    end
  end

  // The read port always prefetches the byte at the next head slot; a byte
  // written to that same slot in this cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wslot] <= item_i.byte_value;
    end
    if (wr_en && (wslot == rd_addr)) begin
      rd_q <= item_i.byte_value;
    end else begin
      rd_q <= store_mem[rd_addr];
    end
  end

endmodule
